>>> rtl/lpe_pkg.sv
package lpe_pkg;

   localparam logic [3:0] HDR_LEN     = 4'd8;
   localparam logic [3:0] MAGIC_LEN   = 4'd4;
   localparam logic [3:0] HDR_VERSION = 4'd4;
   localparam logic [3:0] HDR_ALG     = 4'd5;
   localparam logic [3:0] HDR_ORACLE  = 4'd6;
   localparam logic [1:0] LAST_FIELD  = 2'd3;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_VERSION = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALG_UNKNOWN      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORACLE_UNKNOWN   = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_SHORT     = 3'd1;
   localparam logic [2:0] ST_MAGIC     = 3'd2;
   localparam logic [2:0] ST_TRUNCATED = 3'd3;
   localparam logic [2:0] ST_TRAILING  = 3'd4;
   localparam logic [2:0] ST_VERSION   = 3'd5;
   localparam logic [2:0] ST_UNKNOWN   = 3'd6;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_LEN_LO  = 3'd1,
      PH_LEN_HI  = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_DONE    = 3'd4
   } phase_type;

   typedef struct packed {
      logic       has_payload;
      logic [1:0] field_index;
      logic [7:0] payload_byte;
      logic       done_res;
      logic [2:0] status;
      logic [7:0] version;
      logic [7:0] algorithm;
      logic [7:0] oracle;
      logic [7:0] flags;
   } rsp_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'h50;
         2'd1:    b = 8'h51;
         2'd2:    b = 8'h43;
         default: b = 8'h46;
      endcase
      return b;
   endfunction

endpackage

>>> rtl/lpe_front.sv
module lpe_front
   import lpe_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_in_byte,
   input  logic                   req_is_last,
   input  logic                   q_full,
   output logic                   push,
   output rsp_type                push_data
);

   logic [7:0]  exp_version_ff, alg_unknown_ff, oracle_unknown_ff;
   phase_type   phase_ff, phase_in;
   logic [3:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [1:0]  field_ff, field_in;
   logic [15:0] left_ff, left_in;
   logic        magic_good_ff, magic_good_in;
   logic        trailing_ff, trailing_in;
   logic [7:0]  version_ff, version_in;
   logic [7:0]  alg_ff, alg_in;
   logic [7:0]  oracle_ff, oracle_in;
   logic [7:0]  flags_ff, flags_in;
   logic        accept, pay;
   logic [2:0]  status;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_version_ff    <= 8'd1;
         alg_unknown_ff    <= 8'd0;
         oracle_unknown_ff <= 8'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_EXPECTED_VERSION: exp_version_ff    <= csr_wdata;
            CSR_ALG_UNKNOWN:      alg_unknown_ff    <= csr_wdata;
            CSR_ORACLE_UNKNOWN:   oracle_unknown_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         hdr_cnt_ff    <= 4'd0;
         field_ff      <= 2'd0;
         left_ff       <= 16'd0;
         magic_good_ff <= 1'b1;
         trailing_ff   <= 1'b0;
         version_ff    <= 8'd0;
         alg_ff        <= 8'd0;
         oracle_ff     <= 8'd0;
         flags_ff      <= 8'd0;
      end else if (accept) begin
         if (req_is_last) begin
            phase_ff      <= PH_HEADER;
            hdr_cnt_ff    <= 4'd0;
            field_ff      <= 2'd0;
            left_ff       <= 16'd0;
            magic_good_ff <= 1'b1;
            trailing_ff   <= 1'b0;
            version_ff    <= 8'd0;
            alg_ff        <= 8'd0;
            oracle_ff     <= 8'd0;
            flags_ff      <= 8'd0;
         end else begin
            phase_ff      <= phase_in;
            hdr_cnt_ff    <= hdr_cnt_in;
            field_ff      <= field_in;
            left_ff       <= left_in;
            magic_good_ff <= magic_good_in;
            trailing_ff   <= trailing_in;
            version_ff    <= version_in;
            alg_ff        <= alg_in;
            oracle_ff     <= oracle_in;
            flags_ff      <= flags_in;
         end
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      hdr_cnt_in    = hdr_cnt_ff;
      field_in      = field_ff;
      left_in       = left_ff;
      magic_good_in = magic_good_ff;
      trailing_in   = trailing_ff;
      version_in    = version_ff;
      alg_in        = alg_ff;
      oracle_in     = oracle_ff;
      flags_in      = flags_ff;
      pay           = 1'b0;
      case (phase_ff)
         PH_HEADER: begin
            if (hdr_cnt_ff < MAGIC_LEN) begin
               if (req_in_byte != magic_byte(hdr_cnt_ff[1:0])) magic_good_in = 1'b0;
            end else if (hdr_cnt_ff == HDR_VERSION) begin
               version_in = req_in_byte;
            end else if (hdr_cnt_ff == HDR_ALG) begin
               alg_in = req_in_byte;
            end else if (hdr_cnt_ff == HDR_ORACLE) begin
               oracle_in = req_in_byte;
            end else begin
               flags_in = req_in_byte;
            end
            if (hdr_cnt_ff < HDR_LEN) hdr_cnt_in = hdr_cnt_ff + 4'd1;
            if (hdr_cnt_in >= HDR_LEN) begin
               phase_in = PH_LEN_LO;
               field_in = 2'd0;
            end
         end
         PH_LEN_LO: begin
            left_in  = {8'd0, req_in_byte};
            phase_in = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            left_in = {req_in_byte, left_ff[7:0]};
            if (left_in == 16'd0) begin
               // zero length: skip straight to the next field, or to done after the last one
               if (field_ff == LAST_FIELD) phase_in = PH_DONE;
               else begin
                  field_in = field_ff + 2'd1;
                  phase_in = PH_LEN_LO;
               end
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            pay     = 1'b1;
            left_in = left_ff - 16'd1;
            if (left_in == 16'd0) begin
               if (field_ff == LAST_FIELD) phase_in = PH_DONE;
               else begin
                  field_in = field_ff + 2'd1;
                  phase_in = PH_LEN_LO;
               end
            end
         end
         default: begin
            trailing_in = 1'b1;
         end
      endcase
   end

   always_comb begin
      if (hdr_cnt_in < HDR_LEN)                   status = ST_SHORT;
      else if (!magic_good_in)                    status = ST_MAGIC;
      else if (phase_in != PH_DONE)               status = ST_TRUNCATED;
      else if (trailing_in)                       status = ST_TRAILING;
      else if (version_in != exp_version_ff)      status = ST_VERSION;
      else if (alg_in == alg_unknown_ff || oracle_in == oracle_unknown_ff)
                                                  status = ST_UNKNOWN;
      else                                        status = ST_OK;
   end

   assign push = accept && (pay || req_is_last);

   always_comb begin
      push_data.has_payload  = pay;
      push_data.field_index  = pay ? field_ff : 2'd0;
      push_data.payload_byte = pay ? req_in_byte : 8'd0;
      push_data.done_res     = req_is_last;
      push_data.status       = req_is_last ? status : ST_OK;
      push_data.version      = version_in;
      push_data.algorithm    = alg_in;
      push_data.oracle       = oracle_in;
      push_data.flags        = flags_in;
   end

endmodule

>>> rtl/lpe_queue.sv
module lpe_queue
   import lpe_pkg::*;
#(
   parameter int unsigned DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output rsp_type head_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   rsp_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      else if (!do_push && do_pop) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

>>> rtl/lpe_back.sv
module lpe_back
   import lpe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  rsp_type head_data,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff;

   // refill the output register when it is empty or its word is taken
   assign pop = head_valid && (!out_valid_ff || rsp_ready);

   always_comb begin
      if (pop) out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
      else out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      if (pop) out_ff <= head_data;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

>>> rtl/length_prefixed_envelope_parser.sv
// A word from an accepted byte is written into the queue, then moved to the output register on rsp_*.
// Throughput: one byte per cycle while the queue is not full; header and length bytes that are not final give no word.
// The parse state machine updates in the cycle a byte is accepted; a small queue and an
// output register follow it, so req_ready drops only when the queue is full.
// Reset is synchronous and active high: it clears parse state, queue and output register,
// and returns the three configuration registers to their defaults.
module length_prefixed_envelope_parser
   import lpe_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_in_byte,
   input  logic                   req_is_last,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_has_payload,
   output logic [1:0]             rsp_field_index,
   output logic [7:0]             rsp_payload_byte,
   output logic                   rsp_done_res,
   output logic [2:0]             rsp_status,
   output logic [7:0]             rsp_version_out,
   output logic [7:0]             rsp_algorithm_out,
   output logic [7:0]             rsp_oracle_out,
   output logic [7:0]             rsp_flags_out
);

   logic    q_full, push, pop, head_valid;
   rsp_type push_data, head_data, rsp_data;

   lpe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .req_is_last (req_is_last),
      .q_full      (q_full),
      .push        (push),
      .push_data   (push_data)
   );

   lpe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   lpe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_has_payload   = rsp_data.has_payload;
   assign rsp_field_index   = rsp_data.field_index;
   assign rsp_payload_byte  = rsp_data.payload_byte;
   assign rsp_done_res      = rsp_data.done_res;
   assign rsp_status        = rsp_data.status;
   assign rsp_version_out   = rsp_data.version;
   assign rsp_algorithm_out = rsp_data.algorithm;
   assign rsp_oracle_out    = rsp_data.oracle;
   assign rsp_flags_out     = rsp_data.flags;

endmodule

>>> rtl/lpe_checker.sv
module lpe_checker
   import lpe_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   csr_we,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [7:0]             csr_wdata,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic [7:0]             req_in_byte,
   input logic                   req_is_last,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_has_payload,
   input logic [1:0]             rsp_field_index,
   input logic [7:0]             rsp_payload_byte,
   input logic                   rsp_done_res,
   input logic [2:0]             rsp_status,
   input logic [7:0]             rsp_version_out,
   input logic [7:0]             rsp_algorithm_out,
   input logic [7:0]             rsp_oracle_out,
   input logic [7:0]             rsp_flags_out
);

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload_byte)
         && $stable(rsp_status) && $stable(rsp_done_res) && $stable(rsp_has_payload))
      else $error("rsp word changed while stalled");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // every word carries a payload byte, a verdict, or both
   a_word_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_has_payload || rsp_done_res)
      else $error("rsp word with neither payload nor verdict");

   a_no_payload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_payload |-> rsp_field_index == 2'd0 && rsp_payload_byte == 8'd0)
      else $error("payload fields set without payload");

   a_status_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_status == ST_OK)
      else $error("status set on a word that is not final");

endmodule

bind length_prefixed_envelope_parser lpe_checker u_checker (.*);

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import lpe_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       pinned;
      rsp_type    want;
   } envelope_row_type;

   localparam logic [7:0] ENVELOPE_MAGIC [4] = '{8'h50, 8'h51, 8'h43, 8'h46};

   // Short header, a clean envelope with one payload byte, and a bad magic.
   // Verdict rows carry the expected word; the payload row goes to the predictor.
   localparam envelope_row_type DIRECTED_ROWS [26] = '{
      '{8'h00, 1'b1, 1'b1,
        '{1'b0, 2'd0, 8'h00, 1'b1, ST_SHORT, 8'h00, 8'h00, 8'h00, 8'h00}},
      '{8'h50, 1'b0, 1'b0, '0},
      '{8'h51, 1'b0, 1'b0, '0},
      '{8'h43, 1'b0, 1'b0, '0},
      '{8'h46, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, '0},
      '{8'h07, 1'b0, 1'b0, '0},
      '{8'h09, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'hAA, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1,
        '{1'b0, 2'd0, 8'h00, 1'b1, ST_OK, 8'h01, 8'h07, 8'h09, 8'hFF}},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h51, 1'b0, 1'b0, '0},
      '{8'h43, 1'b0, 1'b0, '0},
      '{8'h46, 1'b0, 1'b0, '0},
      '{8'h05, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h80, 1'b1, 1'b1,
        '{1'b0, 2'd0, 8'h00, 1'b1, ST_MAGIC, 8'h05, 8'h00, 8'h00, 8'h80}}
   };

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [7:0]             csr_wdata = 8'h00;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_in_byte = 8'h00;
   logic                   req_is_last = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_has_payload;
   logic [1:0]             rsp_field_index;
   logic [7:0]             rsp_payload_byte;
   logic                   rsp_done_res;
   logic [2:0]             rsp_status;
   logic [7:0]             rsp_version_out;
   logic [7:0]             rsp_algorithm_out;
   logic [7:0]             rsp_oracle_out;
   logic [7:0]             rsp_flags_out;

   // predictor copy of the parse state and the registers
   logic [3:0]  hdr_count = 4'd0;
   phase_type   parse_phase = PH_HEADER;
   logic [1:0]  field_no = 2'd0;
   logic [15:0] remaining = 16'd0;
   logic        magic_ok = 1'b1;
   logic        trailing = 1'b0;
   logic [7:0]  seen_version = 8'h00;
   logic [7:0]  seen_algorithm = 8'h00;
   logic [7:0]  seen_oracle = 8'h00;
   logic [7:0]  seen_flags = 8'h00;
   logic [7:0]  cfg_version = 8'h01;
   logic [7:0]  cfg_alg_unknown = 8'h00;
   logic [7:0]  cfg_oracle_unknown = 8'h00;

   rsp_type     predicted_words [$];
   logic [7:0]  envelope_bytes [$];
   int unsigned error_count = 0;
   bit          idling_on = 1'b1;
   int unsigned stall_left = 0;

   length_prefixed_envelope_parser dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_is_last       (req_is_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_has_payload   (rsp_has_payload),
      .rsp_field_index   (rsp_field_index),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_done_res      (rsp_done_res),
      .rsp_status        (rsp_status),
      .rsp_version_out   (rsp_version_out),
      .rsp_algorithm_out (rsp_algorithm_out),
      .rsp_oracle_out    (rsp_oracle_out),
      .rsp_flags_out     (rsp_flags_out)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("%0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
      error_count++;
   endtask

   function automatic void close_field();
      if (field_no >= LAST_FIELD) begin
         parse_phase = PH_DONE;
      end else begin
         field_no = field_no + 2'd1;
         parse_phase = PH_LEN_LO;
      end
   endfunction

   task automatic advance_parse(input logic [7:0] b, input logic last,
                                output bit emits, output rsp_type word);
      bit         pay;
      logic [1:0] pay_field;
      logic [2:0] verdict;
      pay = 1'b0;
      pay_field = 2'd0;
      verdict = ST_OK;
      word = '0;
      case (parse_phase)
         PH_HEADER: begin
            if (hdr_count < MAGIC_LEN) begin
               if (b != ENVELOPE_MAGIC[hdr_count[1:0]]) magic_ok = 1'b0;
            end else if (hdr_count == HDR_VERSION) begin
               seen_version = b;
            end else if (hdr_count == HDR_ALG) begin
               seen_algorithm = b;
            end else if (hdr_count == HDR_ORACLE) begin
               seen_oracle = b;
            end else begin
               seen_flags = b;
            end
            if (hdr_count < HDR_LEN) hdr_count = hdr_count + 4'd1;
            if (hdr_count >= HDR_LEN) begin
               parse_phase = PH_LEN_LO;
               field_no = 2'd0;
            end
         end
         PH_LEN_LO: begin
            remaining = {8'h00, b};
            parse_phase = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            remaining[15:8] = b;
            if (remaining == 16'd0) close_field();
            else parse_phase = PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            pay = 1'b1;
            pay_field = field_no;
            remaining = remaining - 16'd1;
            if (remaining == 16'd0) close_field();
         end
         default: trailing = 1'b1;
      endcase
      emits = pay || last;
      if (last) begin
         if (hdr_count < HDR_LEN) verdict = ST_SHORT;
         else if (!magic_ok) verdict = ST_MAGIC;
         else if (parse_phase != PH_DONE) verdict = ST_TRUNCATED;
         else if (trailing) verdict = ST_TRAILING;
         else if (seen_version != cfg_version) verdict = ST_VERSION;
         else if (seen_algorithm == cfg_alg_unknown || seen_oracle == cfg_oracle_unknown)
            verdict = ST_UNKNOWN;
      end
      word.has_payload  = pay;
      word.field_index  = pay_field;
      word.payload_byte = pay ? b : 8'h00;
      word.done_res     = last;
      word.status       = verdict;
      word.version      = seen_version;
      word.algorithm    = seen_algorithm;
      word.oracle       = seen_oracle;
      word.flags        = seen_flags;
      if (last) begin
         // a final byte starts the next message from scratch
         hdr_count = 4'd0;
         parse_phase = PH_HEADER;
         field_no = 2'd0;
         remaining = 16'd0;
         magic_ok = 1'b1;
         trailing = 1'b0;
         seen_version = 8'h00;
         seen_algorithm = 8'h00;
         seen_oracle = 8'h00;
         seen_flags = 8'h00;
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last, input logic pinned,
                            input rsp_type pinned_word);
      bit      emits;
      rsp_type word;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_is_last <= last;
      do @(posedge clock); while (!req_ready);
      advance_parse(b, last, emits, word);
      if (emits) predicted_words.push_back(pinned ? pinned_word : word);
   endtask

   task automatic write_settings(input logic [7:0] version, input logic [7:0] alg,
                                 input logic [7:0] oracle);
      // hold off until every word is out and the pipeline is empty
      req_valid <= 1'b0;
      while (predicted_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_EXPECTED_VERSION;
      csr_wdata <= version;
      @(posedge clock);
      csr_index <= CSR_ALG_UNKNOWN;
      csr_wdata <= alg;
      @(posedge clock);
      csr_index <= CSR_ORACLE_UNKNOWN;
      csr_wdata <= oracle;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_version = version;
      cfg_alg_unknown = alg;
      cfg_oracle_unknown = oracle;
   endtask

   task automatic build_envelope(input bit allow_long);
      int unsigned kind;
      int unsigned keep;
      logic [15:0] flen;
      envelope_bytes.delete();
      kind = $urandom_range(0, 99);
      if (kind >= 95) begin
         repeat ($urandom_range(1, 12)) envelope_bytes.push_back(8'($urandom));
         return;
      end
      foreach (ENVELOPE_MAGIC[i]) envelope_bytes.push_back(ENVELOPE_MAGIC[i]);
      envelope_bytes.push_back($urandom_range(0, 2) != 0 ? cfg_version : 8'($urandom));
      envelope_bytes.push_back($urandom_range(0, 6) == 0 ? cfg_alg_unknown : 8'($urandom));
      envelope_bytes.push_back($urandom_range(0, 6) == 0 ? cfg_oracle_unknown
                                                         : 8'($urandom));
      envelope_bytes.push_back(8'($urandom));
      for (int f = 0; f < 4; f++) begin
         flen = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
         // long fields only early in the run, so the byte count stays near its target
         if (allow_long && $urandom_range(0, 11) == 0) flen = 16'($urandom_range(250, 300));
         envelope_bytes.push_back(flen[7:0]);
         envelope_bytes.push_back(flen[15:8]);
         repeat (flen) envelope_bytes.push_back(8'($urandom));
      end
      if (kind >= 60 && kind < 70) begin
         // drop the tail anywhere, header included
         keep = $urandom_range(1, envelope_bytes.size() - 1);
         while (envelope_bytes.size() > keep) void'(envelope_bytes.pop_back());
      end else if (kind >= 70 && kind < 80) begin
         repeat ($urandom_range(1, 4)) envelope_bytes.push_back(8'($urandom));
      end else if (kind >= 80 && kind < 88) begin
         keep = $urandom_range(0, 3);
         envelope_bytes[keep] = envelope_bytes[keep] ^ 8'($urandom_range(1, 255));
      end else if (kind >= 88) begin
         // huge first length, cut short by the message end
         envelope_bytes[8] = 8'($urandom);
         envelope_bytes[9] = 8'($urandom_range(1, 255));
      end
   endtask

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 8);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_words.size() == 0) begin
            report_mismatch("word with none pending, payload_byte", rsp_payload_byte, 8'h00);
         end else begin
            want = predicted_words.pop_front();
            if (rsp_has_payload !== want.has_payload)
               report_mismatch("has_payload", 8'(rsp_has_payload), 8'(want.has_payload));
            if (rsp_field_index !== want.field_index)
               report_mismatch("field_index", 8'(rsp_field_index), 8'(want.field_index));
            if (rsp_payload_byte !== want.payload_byte)
               report_mismatch("payload_byte", rsp_payload_byte, want.payload_byte);
            if (rsp_done_res !== want.done_res)
               report_mismatch("done_res", 8'(rsp_done_res), 8'(want.done_res));
            if (rsp_status !== want.status)
               report_mismatch("status", 8'(rsp_status), 8'(want.status));
            if (rsp_version_out !== want.version)
               report_mismatch("version_out", rsp_version_out, want.version);
            if (rsp_algorithm_out !== want.algorithm)
               report_mismatch("algorithm_out", rsp_algorithm_out, want.algorithm);
            if (rsp_oracle_out !== want.oracle)
               report_mismatch("oracle_out", rsp_oracle_out, want.oracle);
            if (rsp_flags_out !== want.flags)
               report_mismatch("flags_out", rsp_flags_out, want.flags);
         end
      end
   end

   initial begin
      int unsigned random_sent;
      int unsigned msg_no;
      random_sent = 0;
      msg_no = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (DIRECTED_ROWS[i])
         send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].pinned,
                   DIRECTED_ROWS[i].want);
      while (random_sent < 400) begin
         if (msg_no % 3 == 0) begin
            case ((msg_no / 3) % 5)
               0: write_settings(8'h00, 8'hFF, 8'hFF);
               1: write_settings(8'hFF, 8'h00, 8'hFF);
               2: write_settings(8'h7F, 8'h80, 8'h00);
               3: write_settings(8'($urandom), 8'($urandom), 8'($urandom));
               default: write_settings(8'h01, 8'h00, 8'h00);
            endcase
         end
         idling_on = (random_sent < 320) && ($urandom_range(0, 3) != 0);
         build_envelope(random_sent < 100);
         foreach (envelope_bytes[i]) begin
            send_byte(envelope_bytes[i], i == envelope_bytes.size() - 1, 1'b0, '0);
            random_sent++;
         end
         msg_no++;
      end
      req_valid <= 1'b0;
      while (predicted_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
